FILE: rtl/shlc_pkg.sv
`default_nettype none

package shlc_pkg;

    // Fixed field widths of the channels and of the configuration registers.
    localparam int unsigned OP_W           = 2;
    localparam int unsigned FIELD_POS_W    = 24;
    localparam int unsigned SPEED_W        = 17;
    localparam int unsigned MAX_POSITION_W = 23;
    localparam int unsigned MAX_SPEED_W    = 16;
    localparam int unsigned CFG_DATA_W     = 23;
    localparam int unsigned CFG_INDEX_W    = 1;
    localparam int unsigned HOMING_W       = 3;

    // Wide signed width used for position compares; covers any position width up to 32.
    localparam int unsigned POS_CMP_W      = 33;

    // The back-off distance is max_position divided by this.
    localparam int unsigned BACKOFF_DIVISOR = 100;

    localparam logic [MAX_POSITION_W-1:0] MAX_POSITION_RESET = 23'd100000;
    localparam logic [MAX_SPEED_W-1:0]    MAX_SPEED_RESET    = 16'd1000;

    typedef enum logic [OP_W-1:0] {
        OP_CALIBRATE = 2'd0,
        OP_RUN       = 2'd1,
        OP_MOVE_TO   = 2'd2,
        OP_SET_SPEED = 2'd3
    } op_t;

    typedef enum logic [HOMING_W-1:0] {
        HOMING_UNCALIBRATED = 3'd0,
        HOMING_SEEKING      = 3'd1,
        HOMING_ON_SWITCH    = 3'd2,
        HOMING_BACKING_OFF  = 3'd3,
        HOMING_CALIBRATED   = 3'd4,
        HOMING_ERROR        = 3'd5
    } homing_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_POSITION = 1'b0,
        CFG_MAX_SPEED    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic done;
        logic stepped;
    } step_flags_t;

endpackage

`default_nettype wire

FILE: rtl/shlc_step.sv
`default_nettype none

module shlc_step
    import shlc_pkg::*;
#(
    parameter int unsigned POSITION_BITS    = 24,
    parameter int unsigned TICKS_PER_SECOND = 1000000,
    localparam int unsigned PHASE_W         = $clog2(TICKS_PER_SECOND)
) (
    input  homing_t                           mode_i,
    input  logic signed [POSITION_BITS-1:0]   pos_i,
    input  logic signed [POSITION_BITS-1:0]   tgt_i,
    input  logic signed [SPEED_W-1:0]         speed_i,
    input  logic [PHASE_W-1:0]                phase_i,
    input  op_t                               op_i,
    input  logic                              switch_level_i,
    input  logic [FIELD_POS_W-1:0]            target_i,
    input  logic [SPEED_W-1:0]                speed_req_i,
    input  logic [MAX_POSITION_W-1:0]         max_position_i,
    input  logic [MAX_SPEED_W-1:0]            max_speed_i,
    output homing_t                           mode_o,
    output logic signed [POSITION_BITS-1:0]   pos_o,
    output logic signed [POSITION_BITS-1:0]   tgt_o,
    output logic signed [SPEED_W-1:0]         speed_o,
    output logic [PHASE_W-1:0]                phase_o,
    output step_flags_t                       flags_o
);

    localparam int unsigned SUM_W = ((PHASE_W > SPEED_W) ? PHASE_W : SPEED_W) + 1;
    localparam logic [SUM_W-1:0] TPS_SUM = SUM_W'(TICKS_PER_SECOND);
    localparam logic [SUM_W-1:0] TPS_MAX = SUM_W'(TICKS_PER_SECOND - 1);
    localparam int unsigned BO_W = 41;
    localparam logic signed [BO_W-1:0] BACKOFF_K = BO_W'(BACKOFF_DIVISOR);

    function automatic logic signed [SPEED_W-1:0] sat_speed(
        input logic signed [SPEED_W:0] s,
        input logic [MAX_SPEED_W-1:0]  lim
    );
        logic signed [SPEED_W:0] hi;
        logic signed [SPEED_W:0] lo;
        logic signed [SPEED_W:0] r;
        hi = $signed({2'b00, lim});
        lo = -hi;
        if (s > hi) begin
            r = hi;
        end else if (s < lo) begin
            r = lo;
        end else begin
            r = s;
        end
        return $signed(r[SPEED_W-1:0]);
    endfunction

    logic                              pressed;
    logic signed [SPEED_W-1:0]         ms_pos;
    logic signed [SPEED_W-1:0]         ms_neg;
    logic signed [POSITION_BITS-1:0]   pos_of_max;
    logic signed [POSITION_BITS-1:0]   tgt_in;
    logic signed [SPEED_W:0]           req_wide;
    logic signed [BO_W-1:0]            pos_plus1;
    logic                              backoff_reached;
    logic [POS_CMP_W-1:0]              max_ext;

    // Mode and axis state after the command-specific part, before the run step.
    homing_t                           pre_mode;
    logic signed [POSITION_BITS-1:0]   pre_pos;
    logic signed [POSITION_BITS-1:0]   pre_tgt;
    logic signed [SPEED_W-1:0]         pre_speed;
    logic                              do_run;
    logic                              from_cal;
    logic                              early_done;

    logic signed [POS_CMP_W-1:0]       pre_pos_w;
    logic                              lim_low;
    logic                              lim_high;
    logic                              dir_neg;
    logic [SPEED_W-1:0]                mag;
    logic [SUM_W-1:0]                  sum;
    logic [SUM_W-1:0]                  wrapped;
    logic [SUM_W-1:0]                  phase_sum;
    logic                              step_hit;
    logic signed [POSITION_BITS-1:0]   pos_stepped;
    logic                              run_done;

    assign pressed    = !switch_level_i;
    assign ms_pos     = $signed({1'b0, max_speed_i});
    assign ms_neg     = -ms_pos;
    assign max_ext    = POS_CMP_W'(max_position_i);
    assign pos_of_max = $signed(max_ext[POSITION_BITS-1:0]);
    assign req_wide   = $signed({speed_req_i[SPEED_W-1], speed_req_i});

    always_comb begin
        logic signed [POS_CMP_W-1:0] t_ext;
        t_ext  = POS_CMP_W'($signed(target_i));
        tgt_in = $signed(t_ext[POSITION_BITS-1:0]);
    end

    // floor(max/100) <= p holds exactly when 100 * (p + 1) > max.
    assign pos_plus1       = BO_W'(pos_i) + BO_W'(1);
    assign backoff_reached = (pos_plus1 * BACKOFF_K) > $signed(BO_W'(max_position_i));

    always_comb begin
        pre_mode   = mode_i;
        pre_pos    = pos_i;
        pre_tgt    = tgt_i;
        pre_speed  = speed_i;
        do_run     = 1'b0;
        from_cal   = 1'b0;
        early_done = 1'b0;
        unique case (op_i)
            OP_CALIBRATE: begin
                from_cal = 1'b1;
                if (pressed) begin
                    pre_mode  = HOMING_ON_SWITCH;
                    pre_speed = ms_pos;
                    do_run    = 1'b1;
                end else begin
                    unique case (mode_i)
                        HOMING_UNCALIBRATED: begin
                            pre_mode  = HOMING_SEEKING;
                            pre_pos   = pos_of_max;
                            pre_tgt   = pos_of_max;
                            pre_speed = ms_neg;
                            do_run    = 1'b1;
                        end
                        HOMING_SEEKING: begin
                            do_run = 1'b1;
                        end
                        HOMING_ON_SWITCH: begin
                            pre_mode  = HOMING_BACKING_OFF;
                            pre_pos   = '0;
                            pre_tgt   = '0;
                            pre_speed = ms_pos;
                            do_run    = 1'b1;
                        end
                        HOMING_BACKING_OFF: begin
                            if (backoff_reached) begin
                                pre_mode   = HOMING_CALIBRATED;
                                pre_pos    = '0;
                                pre_tgt    = '0;
                                pre_speed  = '0;
                                early_done = 1'b1;
                            end else begin
                                do_run = 1'b1;
                            end
                        end
                        HOMING_CALIBRATED: begin
                            pre_speed  = '0;
                            early_done = 1'b1;
                        end
                        default: begin
                            // Error and the unused codes all settle in error.
                            pre_mode = HOMING_ERROR;
                        end
                    endcase
                end
            end
            OP_RUN: begin
                do_run = 1'b1;
            end
            OP_MOVE_TO: begin
                pre_tgt = tgt_in;
                if (pos_i > tgt_in) begin
                    pre_speed = sat_speed(-req_wide, max_speed_i);
                end else begin
                    pre_speed = sat_speed(req_wide, max_speed_i);
                end
            end
            OP_SET_SPEED: begin
                pre_speed = sat_speed(req_wide, max_speed_i);
            end
        endcase
    end

    // Run step datapath on the prepared state.
    assign pre_pos_w   = POS_CMP_W'(pre_pos);
    assign lim_low     = pre_pos_w <= 0;
    assign lim_high    = !lim_low && (pre_pos_w >= $signed(max_ext));
    assign dir_neg     = pre_speed[SPEED_W-1];
    assign mag         = dir_neg ? SPEED_W'(-pre_speed) : SPEED_W'(pre_speed);
    assign sum         = SUM_W'(phase_i) + SUM_W'(mag);
    assign step_hit    = sum >= TPS_SUM;
    assign wrapped     = sum - TPS_SUM;
    assign phase_sum   = step_hit ? ((wrapped >= TPS_SUM) ? TPS_MAX : wrapped) : sum;
    assign pos_stepped = dir_neg ? (pre_pos - POSITION_BITS'(1)) : (pre_pos + POSITION_BITS'(1));

    always_comb begin
        mode_o          = pre_mode;
        pos_o           = pre_pos;
        tgt_o           = pre_tgt;
        speed_o         = pre_speed;
        phase_o         = phase_i;
        run_done        = 1'b0;
        flags_o.stepped = 1'b0;
        if (do_run && (pre_mode != HOMING_ERROR)) begin
            priority if (pre_mode == HOMING_CALIBRATED && pressed) begin
                mode_o  = HOMING_ERROR;
                speed_o = '0;
            end else if (pre_speed == '0) begin
                run_done = 1'b1;
            end else if (!lim_low && !lim_high && (pre_pos == pre_tgt)) begin
                speed_o  = '0;
                run_done = 1'b1;
            end else if ((lim_low && dir_neg) || (lim_high && !dir_neg)) begin
                speed_o  = '0;
                run_done = 1'b1;
            end else begin
                phase_o = phase_sum[PHASE_W-1:0];
                if (step_hit) begin
                    pos_o           = pos_stepped;
                    flags_o.stepped = 1'b1;
                end
            end
        end
        // A move that ends during homing means the switch was never found.
        if (from_cal && run_done) begin
            mode_o = HOMING_ERROR;
        end
        flags_o.done = early_done || (run_done && !from_cal);
    end

endmodule

`default_nettype wire

FILE: rtl/stepper_homing_limit_controller_top.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  operation, end_switch_level, target_position,
//                                         speed_request
// m_        out        m_valid / m_ready  done_res, step_pulse, step_direction,
//                                         current_position, homing_state
// cfg_      in         cfg_wr_en          cfg_index, cfg_data (no read-back)
//
// An accepted beat is registered in the input register, then its result moves into the
// output register once that register is empty or being read, and m_valid rises. One beat
// per cycle is sustained while m_ready stays high.
// The axis state is updated by a single pass through the step logic, so back-to-back beats
// each see the state left by the previous one.
// Synchronous active-low reset clears the axis state and the valid flags and loads the
// configuration registers with their defaults.
// When m_ready is low the output holds, the input register keeps its beat, and s_ready
// drops only once both stages are full.
`default_nettype none

module stepper_homing_limit_controller_top
    import shlc_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = 1000000,
    parameter int unsigned POSITION_BITS    = 24
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [OP_W-1:0]            s_operation,
    input  wire logic                       s_end_switch_level,
    input  wire logic [FIELD_POS_W-1:0]     s_target_position,
    input  wire logic [SPEED_W-1:0]         s_speed_request,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_done_res,
    output logic                            m_step_pulse,
    output logic                            m_step_direction,
    output logic [FIELD_POS_W-1:0]          m_current_position,
    output logic [HOMING_W-1:0]             m_homing_state
);

    localparam int unsigned PHASE_W = $clog2(TICKS_PER_SECOND);

    logic [MAX_POSITION_W-1:0]          max_position_reg;
    logic [MAX_SPEED_W-1:0]             max_speed_reg;

    homing_t                            mode_reg;
    homing_t                            mode_next;
    logic signed [POSITION_BITS-1:0]    pos_reg;
    logic signed [POSITION_BITS-1:0]    pos_next;
    logic signed [POSITION_BITS-1:0]    tgt_reg;
    logic signed [POSITION_BITS-1:0]    tgt_next;
    logic signed [SPEED_W-1:0]          speed_reg;
    logic signed [SPEED_W-1:0]          speed_next;
    logic [PHASE_W-1:0]                 phase_reg;
    logic [PHASE_W-1:0]                 phase_next;
    step_flags_t                        flags;

    logic                               in_valid_reg;
    op_t                                in_op_reg;
    logic                               in_level_reg;
    logic [FIELD_POS_W-1:0]             in_target_reg;
    logic [SPEED_W-1:0]                 in_speed_reg;

    logic                               out_valid_reg;
    logic                               out_done_reg;
    logic                               out_step_reg;
    logic                               out_dir_reg;
    logic [FIELD_POS_W-1:0]             out_pos_reg;
    logic [HOMING_W-1:0]                out_mode_reg;

    logic                               in_take;
    logic                               advance;
    logic signed [POS_CMP_W-1:0]        pos_next_wide;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_position_reg <= MAX_POSITION_RESET;
            max_speed_reg    <= MAX_SPEED_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MAX_POSITION: max_position_reg <= cfg_data[MAX_POSITION_W-1:0];
                CFG_MAX_SPEED:    max_speed_reg    <= cfg_data[MAX_SPEED_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_op_reg     <= op_t'(s_operation);
            in_level_reg  <= s_end_switch_level;
            in_target_reg <= s_target_position;
            in_speed_reg  <= s_speed_request;
        end
    end

    shlc_step #(
        .POSITION_BITS    (POSITION_BITS),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_step (
        .mode_i         (mode_reg),
        .pos_i          (pos_reg),
        .tgt_i          (tgt_reg),
        .speed_i        (speed_reg),
        .phase_i        (phase_reg),
        .op_i           (in_op_reg),
        .switch_level_i (in_level_reg),
        .target_i       (in_target_reg),
        .speed_req_i    (in_speed_reg),
        .max_position_i (max_position_reg),
        .max_speed_i    (max_speed_reg),
        .mode_o         (mode_next),
        .pos_o          (pos_next),
        .tgt_o          (tgt_next),
        .speed_o        (speed_next),
        .phase_o        (phase_next),
        .flags_o        (flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= HOMING_UNCALIBRATED;
            pos_reg   <= '0;
            tgt_reg   <= '0;
            speed_reg <= '0;
            phase_reg <= '0;
        end else if (advance) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            tgt_reg   <= tgt_next;
            speed_reg <= speed_next;
            phase_reg <= phase_next;
        end
    end

    assign pos_next_wide = POS_CMP_W'(pos_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_done_reg <= flags.done;
            out_step_reg <= flags.stepped;
            out_dir_reg  <= (speed_next > 0);
            out_pos_reg  <= pos_next_wide[FIELD_POS_W-1:0];
            out_mode_reg <= mode_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_done_res         = out_done_reg;
    assign m_step_pulse       = out_step_reg;
    assign m_step_direction   = out_dir_reg;
    assign m_current_position = out_pos_reg;
    assign m_homing_state     = out_mode_reg;

    // The phase accumulator never reaches one full second of ticks.
    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg < TICKS_PER_SECOND)
        else $error("phase accumulator out of range");

    // Saturation keeps the speed magnitude within 16 bits.
    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        speed_reg != $signed(17'h10000))
        else $error("speed left the saturation range");

    // Only calibrate and run beats can issue a step.
    a_step_ops: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && flags.stepped |-> (in_op_reg == OP_CALIBRATE) || (in_op_reg == OP_RUN))
        else $error("step issued by a command that does not step");

    // A finished command never issues a step on the same beat.
    a_done_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> !(flags.done && flags.stepped))
        else $error("done and step on the same beat");

    // Every beat that leaves the input register shows up at the output.
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("result lost after advance");

endmodule

`default_nettype wire
